FILE: src/cds_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the segment decoder for the clock display scan block.
// No dependencies; every other file of the block imports this package.
package cds_pkg;

  localparam int unsigned NumDigits      = 4;
  localparam int unsigned MaxSteps       = 5;
  localparam int unsigned QueueDepthDflt = 2;
  localparam int unsigned DelayReset     = 5;

  localparam logic [6:0] SegDash = 7'h40;
  localparam logic [6:0] SatMax  = 7'd99;

  typedef enum logic [2:0] {
    KIND_TIME      = 3'd0,
    KIND_BLINK_HRS = 3'd1,
    KIND_BLINK_MIN = 3'd2,
    KIND_DASH_HRS  = 3'd3,
    KIND_DASH_MIN  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [5:0] seconds;
  } req_t;

  typedef struct packed {
    logic [3:0] digit_on;
    logic [6:0] segments;
    logic [1:0] dwell_units;
    logic       colon_on;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [NumDigits-1:0] digit_on;
    logic [6:0]           segments;
    logic [1:0]           dwell_units;
  } step_t;

  typedef struct packed {
    step_t [MaxSteps-1:0] steps;
    logic [2:0]           cnt;
    logic                 colon;
  } plan_t;

  typedef struct packed {
    step_t [1:0] s;
    logic [1:0]  cnt;
  } group_t;

  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

FILE: src/clock_display_scan.sv
`timescale 1ns / 1ps
// The first scan result appears after the request is written into the plan queue and then registered by the sequencer.
// Throughput: one result per cycle while a plan is queued; a request gives one to five results, set by its step count.
// A small plan queue lets new requests enter while the sequencer emits earlier ones.
// Reset (asynchronous, active low) empties the queue and sets the dwell unit register to 5.
// Results cannot be stalled by the receiver. Depends on cds_pkg and the cds_* modules.
module clock_display_scan #(
  parameter int unsigned QueueDepth = cds_pkg::QueueDepthDflt
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cds_pkg::req_t req_i,
  output logic          res_valid_o,
  output cds_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);
  import cds_pkg::*;

  plan_t       plan, head;
  logic        full, head_valid, pop;
  logic [15:0] dwell_unit_q;

  // The dwell unit is held for software; the scan sequence itself does not depend on it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_unit_q <= 16'(DelayReset);
    end else if (cfg_we_i) begin
      dwell_unit_q <= cfg_wdata_i;
    end
  end

  cds_front u_front (
    .req_i  (req_i),
    .plan_o (plan)
  );

  cds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (start_i),
    .plan_i       (plan),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  assign busy_o = full;

`ifndef SYNTHESIS
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> dwell_unit_q == $past(cfg_wdata_i))
    else $error("dwell unit register not written");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !head_valid) |-> ##2 res_valid_o)
    else $error("accepted request on an idle block gave no result");
  a_busy_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> head_valid)
    else $error("busy with an empty queue");
`endif

endmodule

FILE: src/cds_front.sv
`timescale 1ns / 1ps
// Request decoder: turns one refresh request into a plan of up to five scan steps.
// Depends on cds_pkg.
module cds_front (
  input  cds_pkg::req_t  req_i,
  output cds_pkg::plan_t plan_o
);
  import cds_pkg::*;

  logic [6:0]  hrs_sat, min_sat;
  logic [13:0] hrs_prod, min_prod;
  logic [3:0]  hrs_tens, hrs_ones, min_tens, min_ones;
  logic [6:0]  hrs_rem, min_rem;
  logic        even;
  group_t      grp_hrs, grp_min, grp_dash0, grp_dash2, grp_off2, grp_off0, grp_none;
  group_t      grp_a, grp_b, grp_c;
  logic [2:0]  off_b, off_c, rel;

  assign hrs_sat  = (req_i.hours > SatMax) ? SatMax : req_i.hours;
  assign min_sat  = (req_i.minutes > SatMax) ? SatMax : req_i.minutes;
  // Values stay below 100, where multiplying by 103/1024 gives the exact tens digit.
  assign hrs_prod = {7'd0, hrs_sat} * 14'd103;
  assign min_prod = {7'd0, min_sat} * 14'd103;
  assign hrs_tens = hrs_prod[13:10];
  assign min_tens = min_prod[13:10];
  assign hrs_rem  = hrs_sat - {hrs_tens, 3'b000} - {2'b00, hrs_tens, 1'b0};
  assign min_rem  = min_sat - {min_tens, 3'b000} - {2'b00, min_tens, 1'b0};
  assign hrs_ones = hrs_rem[3:0];
  assign min_ones = min_rem[3:0];
  assign even     = ~req_i.seconds[0];

  always_comb begin
    grp_hrs = '0;
    if (hrs_tens != 4'd0) begin
      grp_hrs.s[0] = '{digit_on: 4'b0001, segments: seg7(hrs_tens), dwell_units: 2'd1};
      grp_hrs.s[1] = '{digit_on: 4'b0010, segments: seg7(hrs_ones), dwell_units: 2'd1};
      grp_hrs.cnt  = 2'd2;
    end else begin
      grp_hrs.s[0] = '{digit_on: 4'b0010, segments: seg7(hrs_ones), dwell_units: 2'd1};
      grp_hrs.cnt  = 2'd1;
    end
    grp_min.s[0]   = '{digit_on: 4'b0100, segments: seg7(min_tens), dwell_units: 2'd1};
    grp_min.s[1]   = '{digit_on: 4'b1000, segments: seg7(min_ones), dwell_units: 2'd1};
    grp_min.cnt    = 2'd2;
    grp_dash0.s[0] = '{digit_on: 4'b0001, segments: SegDash, dwell_units: 2'd1};
    grp_dash0.s[1] = '{digit_on: 4'b0010, segments: SegDash, dwell_units: 2'd1};
    grp_dash0.cnt  = 2'd2;
    grp_dash2.s[0] = '{digit_on: 4'b0100, segments: SegDash, dwell_units: 2'd1};
    grp_dash2.s[1] = '{digit_on: 4'b1000, segments: SegDash, dwell_units: 2'd1};
    grp_dash2.cnt  = 2'd2;
    grp_off2       = '0;
    grp_off2.s[0].dwell_units = 2'd2;
    grp_off2.cnt   = 2'd1;
    grp_off0       = '0;
    grp_off0.cnt   = 2'd1;
    grp_none       = '0;
  end

  always_comb begin
    unique case (req_i.kind)
      KIND_TIME: begin
        grp_a = grp_hrs;
        grp_b = grp_min;
        grp_c = grp_off0;
      end
      KIND_BLINK_HRS: begin
        grp_a = even ? grp_hrs : grp_off2;
        grp_b = grp_min;
        grp_c = grp_none;
      end
      KIND_BLINK_MIN: begin
        grp_a = grp_hrs;
        grp_b = even ? grp_min : grp_off2;
        grp_c = grp_none;
      end
      KIND_DASH_HRS: begin
        grp_a = even ? grp_dash0 : grp_off2;
        grp_b = grp_dash2;
        grp_c = grp_none;
      end
      KIND_DASH_MIN: begin
        grp_a = grp_dash0;
        grp_b = even ? grp_dash2 : grp_off2;
        grp_c = grp_none;
      end
      default: begin
        grp_a = grp_off0;
        grp_b = grp_none;
        grp_c = grp_none;
      end
    endcase
  end

  assign off_b = {1'b0, grp_a.cnt};
  assign off_c = off_b + {1'b0, grp_b.cnt};

  always_comb begin
    plan_o       = '0;
    plan_o.cnt   = off_c + {1'b0, grp_c.cnt};
    plan_o.colon = even;
    rel          = '0;
    for (int i = 0; i < MaxSteps; i++) begin
      if (3'(i) < off_b) begin
        plan_o.steps[i] = grp_a.s[i[0]];
      end else if (3'(i) < off_c) begin
        rel             = 3'(i) - off_b;
        plan_o.steps[i] = grp_b.s[rel[0]];
      end else begin
        plan_o.steps[i] = grp_c.s[0];
      end
    end
  end

endmodule

FILE: src/cds_queue.sv
`timescale 1ns / 1ps
// Small queue of decoded scan plans between the request decoder and the sequencer.
// Depends on cds_pkg.
module cds_queue #(
  parameter int unsigned Depth = cds_pkg::QueueDepthDflt
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cds_pkg::plan_t plan_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output cds_pkg::plan_t head_o
);
  import cds_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  plan_t             mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= plan_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop requested from an empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

FILE: src/cds_back.sv
`timescale 1ns / 1ps
// Scan sequencer: walks the head plan one step per cycle into the registered result.
// Depends on cds_pkg.
module cds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  cds_pkg::plan_t head_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output cds_pkg::res_t  res_o
);
  import cds_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       valid_q;
  res_t       res_q, res_d;
  logic       is_last;
  step_t      cur;

  assign cur     = head_i.steps[idx_q];
  assign is_last = (idx_q == head_i.cnt - 3'd1);
  assign pop_o   = head_valid_i & is_last;

  always_comb begin
    idx_d = idx_q;
    if (head_valid_i) begin
      idx_d = is_last ? '0 : idx_q + 3'd1;
    end
    res_d.digit_on    = cur.digit_on;
    res_d.segments    = cur.segments;
    res_d.dwell_units = cur.dwell_units;
    res_d.colon_on    = head_i.colon;
    res_d.last        = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_idx_in_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_i.cnt)
    else $error("step index beyond plan length");
  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($onehot0(res_o.digit_on) &&
                     (res_o.digit_on != 4'd0 || res_o.segments == 7'd0)))
    else $error("bad digit enable or lit segments on an all-off step");
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 3'd0)
    else $error("step index not reset after last step");
`endif

endmodule
